>>> sv/linear_regression_gd_trainer_core_defines.svh
// assertion macros for the gradient descent trainer core
// used by linear_regression_gd_trainer_core.sv, expects clk and rst_n in scope
`ifndef LINEAR_REGRESSION_GD_TRAINER_CORE_DEFINES_SVH
`define LINEAR_REGRESSION_GD_TRAINER_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LRGD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define LRGD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/lrgd_pkg.sv
// shared types, constants and saturation helpers for the trainer core
// no dependencies
package lrgd_pkg;

    localparam int DEF_MAX_SAMPLES  = 256;
    localparam int DEF_MAX_FEATURES = 8;

    localparam int IN_W      = 48;
    localparam int OUT_W     = 40;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int ACC_W     = 64;
    localparam int CNT_W     = 9;
    localparam int IDX_W     = 5;

    localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EPOCH_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FEATURE_COUNT = 2'd3;

    localparam logic [15:0] RST_LEARNING_RATE = 16'd655;
    localparam logic [15:0] RST_EPOCH_COUNT   = 16'd1000;
    localparam logic [8:0]  RST_SAMPLE_COUNT  = 9'd256;
    localparam logic [3:0]  RST_FEATURE_COUNT = 4'd8;

    typedef struct packed {
        logic busy;
        logic done;
    } lrgd_div_stat_t;

    function automatic logic signed [32:0] sat33(input logic signed [63:0] v);
        logic signed [32:0] r;
        if (v > 64'sh0000_0000_FFFF_FFFF)
            r = 33'sh0_FFFF_FFFF;
        else if (v < -64'sh0000_0001_0000_0000)
            r = 33'sh1_0000_0000;
        else
            r = v[32:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sh0000_0000_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

>>> sv/lrgd_div.sv
// restoring divider: signed 64 bit dividend by unsigned 9 bit divisor
// one quotient bit per cycle, magnitude and sign out; depends on lrgd_pkg
module lrgd_div
    import lrgd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [ACC_W-1:0] dividend,
    input  logic [CNT_W-1:0]        divisor,
    output logic [ACC_W-1:0]        quotient,
    output logic                    quot_neg,
    output lrgd_div_stat_t          stat
);

    localparam int STEP_W = $clog2(ACC_W);

    logic                busy_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [CNT_W-1:0]    rem_reg;
    logic [CNT_W-1:0]    den_reg;
    logic [ACC_W-1:0]    num_reg;
    logic                neg_reg;

    logic [CNT_W:0]      trial;
    logic                ge;
    logic [CNT_W-1:0]    rem_next;

    always_comb
    begin
        trial    = {rem_reg, num_reg[ACC_W-1]};
        ge       = (trial >= {1'b0, den_reg});
        rem_next = ge ? CNT_W'(trial - {1'b0, den_reg}) : CNT_W'(trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            num_reg  <= '0;
            neg_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                rem_reg  <= '0;
                den_reg  <= divisor;
                neg_reg  <= dividend[ACC_W-1];
                num_reg  <= dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
            end
            else if (busy_reg)
            begin
                num_reg  <= {num_reg[ACC_W-2:0], ge};
                rem_reg  <= rem_next;
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(ACC_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient  = num_reg;
    assign quot_neg  = neg_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

>>> sv/linear_regression_gd_trainer_core.sv
// batch gradient descent linear regression trainer, signed Q16.16
// depends on lrgd_pkg, lrgd_div and the assertion macro header
// load word: taken only while idle, stored in the feature or target memory, dropped if its slot is above the target
// start word: runs the configured epochs, each limited by the single feature memory
//   read port and the bit-serial divider used once per coefficient
// then nf+1 result words, one per cycle while the sink is ready
// reset: config to defaults, weights, bias and gradient sums to zero; memories not cleared
`include "linear_regression_gd_trainer_core_defines.svh"

module linear_regression_gd_trainer_core
    import lrgd_pkg::*;
#(
    parameter int MAX_SAMPLES  = DEF_MAX_SAMPLES,
    parameter int MAX_FEATURES = DEF_MAX_FEATURES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // config write port
    input  logic                 cfg_wen,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // load words
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_W-1:0]      s_tdata,   // sample_index[7:0], feature_index[11:8], value[43:12]
    input  logic                 s_tuser,   // start_req
    // coefficient words
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_W-1:0]     m_tdata,   // coef_index[3:0], coef_value[35:4]
    output logic                 m_tlast
);

    localparam int SA_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int FA_W = (MAX_SAMPLES * MAX_FEATURES > 1) ?
                          $clog2(MAX_SAMPLES * MAX_FEATURES) : 1;
    localparam int WI_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int AI_W = $clog2(MAX_FEATURES + 1);

    // sequencer states
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_INIT   = 4'd1;
    localparam logic [3:0] ST_EPOCH  = 4'd2;
    localparam logic [3:0] ST_PRED   = 4'd3;
    localparam logic [3:0] ST_PDRAIN = 4'd4;
    localparam logic [3:0] ST_GRAD   = 4'd5;
    localparam logic [3:0] ST_GDRAIN = 4'd6;
    localparam logic [3:0] ST_DIV    = 4'd7;
    localparam logic [3:0] ST_DWAIT  = 4'd8;
    localparam logic [3:0] ST_MLO    = 4'd9;
    localparam logic [3:0] ST_MHI    = 4'd10;
    localparam logic [3:0] ST_STEP   = 4'd11;
    localparam logic [3:0] ST_UPD    = 4'd12;
    localparam logic [3:0] ST_OUT    = 4'd13;

    // config registers
    logic [15:0] lr_reg;
    logic [15:0] epochs_reg;
    logic [8:0]  samples_reg;
    logic [3:0]  features_reg;

    // effective counts, clamped into range
    logic [3:0]  nf;
    logic [8:0]  ns;

    always_comb
    begin
        nf = features_reg;
        if (features_reg == 4'd0)
            nf = 4'd1;
        else if (int'(features_reg) > MAX_FEATURES)
            nf = 4'(MAX_FEATURES);
        ns = samples_reg;
        if (samples_reg == 9'd0)
            ns = 9'd1;
        else if (int'(samples_reg) > MAX_SAMPLES)
            ns = 9'(MAX_SAMPLES);
    end

    // input word fields
    logic [7:0]         in_si;
    logic [3:0]         in_fi;
    logic signed [31:0] in_val;
    logic               in_start;
    logic               in_take;

    assign in_si    = s_tdata[7:0];
    assign in_fi    = s_tdata[11:8];
    assign in_val   = s_tdata[43:12];
    assign in_start = s_tuser;
    assign in_take  = s_tvalid && s_tready;

    // sequencer state and loop counters
    logic [3:0]       state_reg;
    logic [8:0]       i_reg;       // sample
    logic [IDX_W-1:0] j_reg;       // feature / coefficient
    logic [15:0]      e_reg;       // epoch

    logic [IDX_W-1:0] nf_x;
    logic             j_at_nf;
    logic             i_at_end;
    assign nf_x     = {1'b0, nf};
    assign j_at_nf  = (j_reg == nf_x);
    assign i_at_end = (i_reg == ns - 9'd1);

    // pipeline stage valids and tags
    logic             p1_valid_reg, p2_valid_reg;
    logic             p1_last_reg,  p2_last_reg;
    logic             p1_grad_reg,  p2_grad_reg;
    logic             p1_bslot_reg;
    logic [IDX_W-1:0] p1_j_reg,     p2_j_reg;
    logic [SA_W-1:0]  p1_i_reg,     p2_i_reg;
    logic signed [31:0] p1_w_reg;
    logic signed [63:0] p2_val_reg;
    logic signed [31:0] p2_tgt_reg;
    logic             drained;
    assign drained = !p1_valid_reg && !p2_valid_reg;

    // model state
    logic signed [31:0] weight_reg [MAX_FEATURES];
    logic signed [31:0] bias_reg;
    logic signed [63:0] accum_reg [MAX_FEATURES + 1];
    logic signed [63:0] acc_reg;   // running prediction

    // ---------------------------------------------------------------
    // training memories, registered read
    // ---------------------------------------------------------------
    logic signed [31:0] feat_mem [MAX_SAMPLES * MAX_FEATURES];
    logic signed [31:0] tgt_mem  [MAX_SAMPLES];
    logic signed [32:0] err_mem  [MAX_SAMPLES];

    logic               slot_ok;
    logic               feat_we, tgt_we;
    logic [FA_W-1:0]    feat_waddr, feat_raddr;
    logic [SA_W-1:0]    tgt_waddr, side_raddr;
    logic [3:0]         feat_col;
    logic signed [31:0] feat_rd_reg, tgt_rd_reg;
    logic signed [32:0] err_rd_reg;
    logic               err_we;
    logic signed [32:0] err_wdata;

    assign slot_ok    = (int'(in_si) < MAX_SAMPLES);
    assign feat_we    = in_take && slot_ok && (in_fi < nf);
    assign tgt_we     = in_take && slot_ok && (in_fi == nf);
    assign feat_waddr = FA_W'(int'(in_si) * MAX_FEATURES + int'(in_fi));
    assign tgt_waddr  = SA_W'(in_si);

    // the bias slot of the gradient pass uses no feature; it reads column 0, which goes unused
    assign feat_col   = j_at_nf ? 4'd0 : j_reg[3:0];
    assign feat_raddr = FA_W'(int'(i_reg) * MAX_FEATURES + int'(feat_col));
    assign side_raddr = SA_W'(i_reg);

    always_ff @(posedge clk)
    begin
        if (feat_we)
            feat_mem[feat_waddr] <= in_val;
        feat_rd_reg <= feat_mem[feat_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (tgt_we)
            tgt_mem[tgt_waddr] <= in_val;
        tgt_rd_reg <= tgt_mem[side_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (err_we)
            err_mem[p2_i_reg] <= err_wdata;
        err_rd_reg <= err_mem[side_raddr];
    end

    // ---------------------------------------------------------------
    // issue: one memory element per cycle in the predict and gradient passes
    // ---------------------------------------------------------------
    logic iss_valid, iss_grad, iss_last;
    assign iss_grad  = (state_reg == ST_GRAD);
    assign iss_valid = (state_reg == ST_PRED) || iss_grad;
    assign iss_last  = iss_grad ? j_at_nf : (j_reg == nf_x - 5'd1);

    // shared weight read port: issue, update and output all use j
    logic [WI_W-1:0]    w_idx;
    logic signed [31:0] w_rd;
    logic signed [31:0] coef_cur;
    assign w_idx    = WI_W'(j_reg);
    assign w_rd     = weight_reg[w_idx];
    assign coef_cur = j_at_nf ? bias_reg : w_rd;

    // stage 1: product of weight*feature or feature*error, floor shift by 16; the bias slot passes the error
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic signed [63:0] p2_val_next;
    always_comb
    begin
        mul_a = p1_grad_reg ? err_rd_reg : {p1_w_reg[31], p1_w_reg};
        mul_b = {feat_rd_reg[31], feat_rd_reg};
        mul_p = mul_a * mul_b;
        if (p1_bslot_reg)
            p2_val_next = {{31{err_rd_reg[32]}}, err_rd_reg};
        else
            p2_val_next = 64'(mul_p >>> 16);
    end

    // stage 2: prediction sum and error, or gradient accumulate
    logic signed [63:0] pred_sum, pred_diff, bias_x;
    logic [AI_W-1:0]    acc_idx;
    logic signed [63:0] accum_rd;
    always_comb
    begin
        bias_x    = {{32{bias_reg[31]}}, bias_reg};
        pred_sum  = acc_reg + p2_val_reg;
        pred_diff = pred_sum - {{32{p2_tgt_reg[31]}}, p2_tgt_reg};
        err_wdata = sat33(pred_diff);
        err_we    = p2_valid_reg && !p2_grad_reg && p2_last_reg;
    end
    assign acc_idx  = (state_reg == ST_DIV) ? AI_W'(j_reg) : AI_W'(p2_j_reg);
    assign accum_rd = accum_reg[acc_idx];

    // ---------------------------------------------------------------
    // update: divide by sample count, scale by learning rate, subtract
    // ---------------------------------------------------------------
    logic [ACC_W-1:0]   div_q;
    logic               div_neg;
    lrgd_div_stat_t     div_stat;

    lrgd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_DIV),
        .dividend (accum_rd),
        .divisor  (ns),
        .quotient (div_q),
        .quot_neg (div_neg),
        .stat     (div_stat)
    );

    // |avg| * lr kept to 64 bits, built from two 32x16 halves
    logic [31:0]        mh_a;
    logic [47:0]        mh_p;
    logic [47:0]        p_lo_reg, p_hi_reg;
    logic [63:0]        mag_reg;     // product plus rounding bias when negative
    logic signed [63:0] upd_sum;
    logic signed [31:0] upd_val;
    always_comb
    begin
        mh_a    = (state_reg == ST_MLO) ? div_q[31:0] : div_q[63:32];
        mh_p    = {16'd0, mh_a} * {32'd0, lr_reg};
        // w - step, where step is floor((avg*lr) / 2^16)
        if (div_neg)
            upd_sum = {{32{coef_cur[31]}}, coef_cur} + {16'd0, mag_reg[63:16]};
        else
            upd_sum = {{32{coef_cur[31]}}, coef_cur} - {16'd0, mag_reg[63:16]};
        upd_val = sat32(upd_sum);
    end

    // output register
    logic               m_tvalid_reg;
    logic [3:0]         m_index_reg;
    logic signed [31:0] m_value_reg;
    logic               m_last_reg;
    logic               out_adv;
    assign out_adv = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    // ---------------------------------------------------------------
    // sequencer, model state and config
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            i_reg        <= '0;
            j_reg        <= '0;
            e_reg        <= '0;
            lr_reg       <= RST_LEARNING_RATE;
            epochs_reg   <= RST_EPOCH_COUNT;
            samples_reg  <= RST_SAMPLE_COUNT;
            features_reg <= RST_FEATURE_COUNT;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            bias_reg     <= '0;
            for (int k = 0; k < MAX_FEATURES; k++)
                weight_reg[k] <= '0;
            for (int k = 0; k <= MAX_FEATURES; k++)
                accum_reg[k] <= '0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_index)
                    REG_LEARNING_RATE: lr_reg       <= cfg_data;
                    REG_EPOCH_COUNT:   epochs_reg   <= cfg_data;
                    REG_SAMPLE_COUNT:  samples_reg  <= cfg_data[8:0];
                    REG_FEATURE_COUNT: features_reg <= cfg_data[3:0];
                    default: ;
                endcase
            end

            p1_valid_reg <= iss_valid;
            p2_valid_reg <= p1_valid_reg;

            if (p2_valid_reg && p2_grad_reg)
                accum_reg[acc_idx] <= accum_rd + p2_val_reg;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_take && in_start)
                        state_reg <= ST_INIT;
                end
                ST_INIT:
                begin
                    bias_reg <= '0;
                    for (int k = 0; k < MAX_FEATURES; k++)
                        weight_reg[k] <= '0;
                    e_reg <= '0;
                    j_reg <= '0;
                    // zero epochs emits the cleared model
                    state_reg <= (epochs_reg == 16'd0) ? ST_OUT : ST_EPOCH;
                end
                ST_EPOCH:
                begin
                    i_reg     <= '0;
                    j_reg     <= '0;
                    state_reg <= ST_PRED;
                end
                ST_PRED:
                begin
                    if (iss_last)
                    begin
                        j_reg <= '0;
                        if (i_at_end)
                            state_reg <= ST_PDRAIN;
                        else
                            i_reg <= i_reg + 9'd1;
                    end
                    else
                        j_reg <= j_reg + 5'd1;
                end
                ST_PDRAIN:
                begin
                    // errors all written before the gradient pass reads them
                    if (drained)
                    begin
                        for (int k = 0; k <= MAX_FEATURES; k++)
                            accum_reg[k] <= '0;
                        i_reg     <= '0;
                        j_reg     <= '0;
                        state_reg <= ST_GRAD;
                    end
                end
                ST_GRAD:
                begin
                    if (iss_last)
                    begin
                        j_reg <= '0;
                        if (i_at_end)
                            state_reg <= ST_GDRAIN;
                        else
                            i_reg <= i_reg + 9'd1;
                    end
                    else
                        j_reg <= j_reg + 5'd1;
                end
                ST_GDRAIN:
                begin
                    if (drained)
                    begin
                        j_reg     <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                    state_reg <= ST_DWAIT;
                ST_DWAIT:
                begin
                    if (div_stat.done)
                        state_reg <= ST_MLO;
                end
                ST_MLO:
                    state_reg <= ST_MHI;
                ST_MHI:
                    state_reg <= ST_STEP;
                ST_STEP:
                    state_reg <= ST_UPD;
                ST_UPD:
                begin
                    if (j_at_nf)
                        bias_reg <= upd_val;
                    else
                        weight_reg[w_idx] <= upd_val;
                    if (j_at_nf)
                    begin
                        j_reg <= '0;
                        if (e_reg == epochs_reg - 16'd1)
                            state_reg <= ST_OUT;
                        else
                        begin
                            e_reg     <= e_reg + 16'd1;
                            state_reg <= ST_EPOCH;
                        end
                    end
                    else
                    begin
                        j_reg     <= j_reg + 5'd1;
                        state_reg <= ST_DIV;
                    end
                end
                ST_OUT:
                begin
                    if (out_adv)
                    begin
                        if (j_reg <= nf_x)
                        begin
                            m_tvalid_reg <= 1'b1;
                            j_reg        <= j_reg + 5'd1;
                        end
                        else
                        begin
                            m_tvalid_reg <= 1'b0;
                            state_reg    <= ST_IDLE;
                        end
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        p1_last_reg  <= iss_last;
        p1_grad_reg  <= iss_grad;
        p1_bslot_reg <= iss_grad && j_at_nf;
        p1_j_reg     <= j_reg;
        p1_i_reg     <= SA_W'(i_reg);
        p1_w_reg     <= w_rd;

        p2_last_reg  <= p1_last_reg;
        p2_grad_reg  <= p1_grad_reg;
        p2_j_reg     <= p1_j_reg;
        p2_i_reg     <= p1_i_reg;
        p2_val_reg   <= p2_val_next;
        p2_tgt_reg   <= tgt_rd_reg;

        if (state_reg == ST_EPOCH)
            acc_reg <= bias_x;
        else if (p2_valid_reg && !p2_grad_reg)
            acc_reg <= p2_last_reg ? bias_x : pred_sum;

        if (state_reg == ST_MLO)
            p_lo_reg <= mh_p;
        if (state_reg == ST_MHI)
            p_hi_reg <= mh_p;
        // low 64 bits of the magnitude product, plus rounding toward minus infinity
        if (state_reg == ST_STEP)
            mag_reg <= {16'd0, p_lo_reg} + {p_hi_reg[31:0], 32'd0}
                       + (div_neg ? 64'h0000_0000_0000_FFFF : 64'd0);

        if (out_adv && (j_reg <= nf_x))
        begin
            m_index_reg <= j_reg[3:0];
            m_value_reg <= coef_cur;
            m_last_reg  <= j_at_nf;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, m_value_reg, m_index_reg};
    assign m_tlast  = m_last_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    `LRGD_ASSERT_IMP(a_no_load_while_out, m_tvalid, !s_tready, "load word taken during output")
    `LRGD_ASSERT_IMP(a_update_after_drain, state_reg == ST_DIV, drained, "update with pipeline busy")
    `LRGD_ASSERT_IMP(a_div_done_in_wait, div_stat.done, state_reg == ST_DWAIT, "stray divider done")
    `LRGD_ASSERT_IMP(a_last_is_bias, m_tvalid && m_tlast, m_tdata[3:0] == nf, "last word not bias")

endmodule

>>> verif/linear_regression_gd_trainer_core_tb.sv
// self-checking testbench for linear_regression_gd_trainer_core
// needs lrgd_pkg and the core; predicts every coefficient word with its own trainer model
`timescale 1ns / 1ps

module linear_regression_gd_trainer_core_tb
    import lrgd_pkg::*;
();

    localparam int N_SAMP = 256;
    localparam int N_FEAT = 8;

    typedef struct {
        bit [7:0]  si;
        bit [3:0]  fi;
        bit [31:0] val;
        bit        start;
    } load_t;

    typedef struct {
        bit [3:0]  idx;
        bit [31:0] val;
        bit        last;
    } coef_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata = '0;     // sample_index[7:0], feature_index[11:8], value[43:12]
    logic                 s_tuser = 1'b0;   // start_req
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_W-1:0]     m_tdata;          // coef_index[3:0], coef_value[35:4]
    logic                 m_tlast;

    linear_regression_gd_trainer_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wen  (cfg_wen),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // stimulus and expectation stores
    load_t load_q[$];
    coef_t coef_q[$];
    int    fails = 0;
    bit    no_idle = 1'b0;
    bit    hold_req = 1'b0;

    // trainer mirror: config and memories
    bit [15:0] lr_r = RST_LEARNING_RATE;
    bit [15:0] epochs_r = RST_EPOCH_COUNT;
    bit [8:0]  samples_r = RST_SAMPLE_COUNT;
    bit [3:0]  features_r = RST_FEATURE_COUNT;
    int        feat_mem[N_SAMP*N_FEAT];
    int        targ_mem[N_SAMP];
    longint    err_mem[N_SAMP];
    int        wts[N_FEAT];
    int        bias_v;

    // which entries the stimulus has written, so training never reads a hole
    bit feat_seen[N_SAMP*N_FEAT];
    bit targ_seen[N_SAMP];

    initial forever #2 clk = ~clk;

    function automatic int eff_ns();
        if (samples_r == 0)
            return 1;
        return (samples_r > N_SAMP) ? N_SAMP : int'(samples_r);
    endfunction

    function automatic int eff_nf();
        if (features_r == 0)
            return 1;
        return (features_r > N_FEAT) ? N_FEAT : int'(features_r);
    endfunction

    // (a*b) >> 16, floor; magnitude product wraps at 64 bits
    function automatic longint q16_mul(longint a, longint b);
        longint unsigned ma, mb, m;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        m = ma * mb;
        if ((a < 0) == (b < 0))
            return longint'(m >> 16);
        return -longint'((m + 64'hFFFF) >> 16);
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // store one word, and on start run the whole training and queue the coefficients
    function automatic void train_step(load_t it);
        int     ns, nf;
        longint acc, avg, stp;
        longint grad[N_FEAT+1];
        coef_t  c;
        ns = eff_ns();
        nf = eff_nf();
        if (it.fi < nf)
            feat_mem[it.si*N_FEAT + it.fi] = it.val;
        else if (it.fi == nf)
            targ_mem[it.si] = it.val;
        if (!it.start)
            return;
        foreach (wts[j])
            wts[j] = 0;
        bias_v = 0;
        for (int e = 0; e < epochs_r; e++)
        begin
            for (int i = 0; i < ns; i++)
            begin
                acc = bias_v;
                for (int j = 0; j < nf; j++)
                    acc += q16_mul(wts[j], feat_mem[i*N_FEAT + j]);
                err_mem[i] = clamp(acc - targ_mem[i], -64'sd4294967296, 64'sd4294967295);
            end
            foreach (grad[j])
                grad[j] = 0;
            for (int i = 0; i < ns; i++)
            begin
                for (int j = 0; j < nf; j++)
                    grad[j] += q16_mul(feat_mem[i*N_FEAT + j], err_mem[i]);
                grad[nf] += err_mem[i];
            end
            for (int j = 0; j <= nf; j++)
            begin
                avg = grad[j] / ns;
                stp = q16_mul(avg, longint'(lr_r));
                if (j < nf)
                    wts[j] = int'(clamp(wts[j] - stp, -64'sd2147483648, 64'sd2147483647));
                else
                    bias_v = int'(clamp(bias_v - stp, -64'sd2147483648, 64'sd2147483647));
            end
        end
        for (int j = 0; j <= nf; j++)
        begin
            c.idx = j[3:0];
            c.val = (j < nf) ? wts[j] : bias_v;
            c.last = (j == nf);
            coef_q = {coef_q, c};
        end
    endfunction

    // load driver: pops pending words, idles in random bursts
    load_t tx_cur;
    int    tx_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                train_step(tx_cur);
            if (!s_tvalid || s_tready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (load_q.size() > 0)
                begin
                    tx_cur = load_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'd0, tx_cur.val, tx_cur.fi, tx_cur.si};
                    s_tuser  <= tx_cur.start;
                    if (!no_idle && $urandom_range(0, 9) == 0)
                        tx_gap = $urandom_range(1, 18);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // coefficient sink: random stalls, plus one long hold once words show up
    int rx_gap = 0;
    int rx_hold = 0;
    bit hold_done = 1'b0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (hold_req && !hold_done && m_tvalid)
            begin
                hold_done = 1'b1;
                rx_hold = 600;
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                m_tready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!no_idle && $urandom_range(0, 9) == 0)
                    rx_gap = $urandom_range(1, 18);
            end
        end
    end

    // checker against the oldest expected coefficient
    coef_t exp_c;
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (coef_q.size() == 0)
            begin
                $error("unexpected coefficient word idx=%0d val=%h", m_tdata[3:0], m_tdata[35:4]);
                fails++;
            end
            else
            begin
                exp_c = coef_q.pop_front();
                if (m_tdata[3:0] !== exp_c.idx)
                begin
                    $error("coef_index expected %0d got %0d", exp_c.idx, m_tdata[3:0]);
                    fails++;
                end
                if (m_tdata[35:4] !== exp_c.val)
                begin
                    $error("coef_value expected %h got %h", exp_c.val, m_tdata[35:4]);
                    fails++;
                end
                if (m_tlast !== exp_c.last)
                begin
                    $error("last expected %0d got %0d", exp_c.last, m_tlast);
                    fails++;
                end
            end
        end
    end

    task automatic wait_idle();
        do
            @(posedge clk);
        while (load_q.size() != 0 || s_tvalid || coef_q.size() != 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_LEARNING_RATE: lr_r = data;
            REG_EPOCH_COUNT:   epochs_r = data;
            REG_SAMPLE_COUNT:  samples_r = data[8:0];
            REG_FEATURE_COUNT: features_r = data[3:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_wen <= 1'b0;
    endtask

    task automatic push_word(bit [7:0] si, bit [3:0] fi, bit [31:0] val, bit start);
        load_t it;
        int    nf;
        nf = eff_nf();
        it.si = si;
        it.fi = fi;
        it.val = val;
        it.start = start;
        if (fi < nf)
            feat_seen[si*N_FEAT + fi] = 1'b1;
        else if (fi == nf)
            targ_seen[si] = 1'b1;
        load_q = {load_q, it};
    endtask

    function automatic bit [31:0] pick_val(bit wide);
        if (wide)
            return $urandom;
        return $urandom_range(0, 32'h1F_FFFF) - 32'h10_0000;
    endfunction

    // full training set for the current config, start on the last word
    task automatic push_set(bit wide, output int n);
        int ns, nf;
        ns = eff_ns();
        nf = eff_nf();
        n = 0;
        for (int i = 0; i < ns; i++)
            for (int j = 0; j <= nf; j++)
            begin
                // ignored words with a slot above the target slot
                if ($urandom_range(0, 15) == 0)
                    push_word(8'($urandom), 4'($urandom_range(nf + 1, 15)), $urandom, 1'b0);
                push_word(8'(i), 4'(j), pick_val(wide), (i == ns - 1) && (j == nf));
                n++;
            end
    endtask

    function automatic bit set_ready();
        for (int i = 0; i < eff_ns(); i++)
        begin
            if (!targ_seen[i])
                return 1'b0;
            for (int j = 0; j < eff_nf(); j++)
                if (!feat_seen[i*N_FEAT + j])
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    bit [31:0] extremes[5] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000};

    initial
    begin
        int n, rnd_items, cnt;
        bit wide;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        // zero epochs: all-zero model, full scale values
        set_reg(REG_LEARNING_RATE, 16'hFFFF);
        set_reg(REG_EPOCH_COUNT, 16'd0);
        set_reg(REG_SAMPLE_COUNT, 16'd1);
        set_reg(REG_FEATURE_COUNT, 16'd1);
        push_word(8'd0, 4'd0, 32'h7FFF_FFFF, 1'b0);
        push_word(8'd0, 4'd1, 32'h8000_0000, 1'b1);
        wait_idle();

        // zero learning rate, counts of zero clamp to one, start on an ignored slot
        set_reg(REG_LEARNING_RATE, 16'd0);
        set_reg(REG_EPOCH_COUNT, 16'd2);
        set_reg(REG_SAMPLE_COUNT, 16'd0);
        set_reg(REG_FEATURE_COUNT, 16'd0);
        push_word(8'd255, 4'd15, 32'h1234_5678, 1'b1);
        wait_idle();

        // feature count above the max clamps to eight, extreme values, smallest step
        set_reg(REG_LEARNING_RATE, 16'd1);
        set_reg(REG_EPOCH_COUNT, 16'd3);
        set_reg(REG_SAMPLE_COUNT, 16'd2);
        set_reg(REG_FEATURE_COUNT, 16'd15);
        cnt = 0;
        for (int i = 0; i < 2; i++)
            for (int j = 0; j <= 8; j++)
            begin
                push_word(8'(i), 4'(j), extremes[cnt % 5], (i == 1) && (j == 8));
                cnt++;
            end
        wait_idle();

        // random phases; the first one queues two runs while the sink holds off
        rnd_items = 0;
        cnt = 0;
        while (rnd_items < 80)
        begin
            wide = ($urandom_range(0, 3) == 0);
            set_reg(REG_LEARNING_RATE, wide ? 16'($urandom_range(1, 64))
                                            : 16'($urandom_range(1, 16'hFFFF)));
            set_reg(REG_EPOCH_COUNT, 16'($urandom_range(1, 4)));
            set_reg(REG_SAMPLE_COUNT, ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 8))
                                                                  : 16'($urandom_range(1, 3)));
            set_reg(REG_FEATURE_COUNT, 16'($urandom_range(1, 8)));
            if (rnd_items > 55)
                no_idle = 1'b1;
            push_set(wide, n);
            rnd_items += n;
            if (cnt == 0)
            begin
                hold_req = 1'b1;
                push_set(wide, n);
                rnd_items += n;
            end
            // retrain on what is already stored, start on an ignored slot
            if ($urandom_range(0, 2) == 0 && set_ready())
            begin
                push_word(8'($urandom), 4'd15, $urandom, 1'b1);
                rnd_items++;
            end
            cnt++;
            wait_idle();
        end

        repeat (30) @(posedge clk);
        if (fails == 0)
            $display("linear_regression_gd_trainer_core_tb OK");
        else
            $display("linear_regression_gd_trainer_core_tb NOT OK");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("linear_regression_gd_trainer_core_tb NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/lrgd_pkg.sv
sv/lrgd_div.sv
sv/linear_regression_gd_trainer_core.sv
verif/linear_regression_gd_trainer_core_tb.sv
